>>> rtl/lif_recurrent_network_step_assert.svh
// Assertion macros for the recurrent spiking network step block
`ifndef LIF_RECURRENT_NETWORK_STEP_ASSERT_SVH
`define LIF_RECURRENT_NETWORK_STEP_ASSERT_SVH
`define LIF_ASSERT_IMPL(label, rst_n, cond, consequence, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consequence)) \
		else $error(msg);
`define LIF_ASSERT_NEXT(label, rst_n, cond, consequence, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consequence)) \
		else $error(msg);
`endif

>>> rtl/lif_pkg.sv
// Shared types and constants for the recurrent spiking network step block
`timescale 1ns / 1ps
package lif_pkg;
	localparam int NEURONS_DEF   = 64;
	localparam int FRAC_BITS_DEF = 12;
	localparam int VAL_W         = 24;
	localparam int DECAY_W       = 16;
	localparam int WEIGHT_W      = 16;
	localparam int THR_W         = 23;
	localparam int IDX_W         = 6;
	localparam logic signed [VAL_W-1:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] SAT_MIN = -24'sh800000;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_MDECAY = 2'd0,
		REG_CDECAY = 2'd1,
		REG_THR    = 2'd2,
		REG_EXTW   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic [DECAY_W-1:0] membrane_decay;
		logic [DECAY_W-1:0] current_decay;
		logic [THR_W-1:0] threshold;
		logic signed [WEIGHT_W-1:0] ext_gain;
	} cfg_t;

	function automatic logic signed [VAL_W-1:0] sat24(input logic signed [47:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 48'(signed'(SAT_MAX)))
			r = SAT_MAX;
		else if (v < 48'(signed'(SAT_MIN)))
			r = SAT_MIN;
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction
endpackage

>>> rtl/lif_cell.sv
// One neuron cell of the state ring: holds current, potential and spike, shifts to its neighbor
`timescale 1ns / 1ps
module lif_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic clear,
	input  logic signed [lif_pkg::VAL_W-1:0] cur_in,
	input  logic signed [lif_pkg::VAL_W-1:0] pot_in,
	input  logic spk_in,
	output logic signed [lif_pkg::VAL_W-1:0] cur_out,
	output logic signed [lif_pkg::VAL_W-1:0] pot_out,
	output logic spk_out
);
	logic signed [lif_pkg::VAL_W-1:0] cur_q, pot_q;
	logic spk_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			pot_q <= '0;
			spk_q <= 1'b0;
		end else if (clear) begin
			cur_q <= '0;
			pot_q <= '0;
			spk_q <= 1'b0;
		end else if (shift) begin
			cur_q <= cur_in;
			pot_q <= pot_in;
			spk_q <= spk_in;
		end
	end
	assign cur_out = cur_q;
	assign pot_out = pot_q;
	assign spk_out = spk_q;
endmodule

>>> rtl/lif_update.sv
// Neuron update datapath: decays, integrates, leaks and fires, registered in stages
`timescale 1ns / 1ps
module lif_update (
	input  logic clk,
	input  logic go,
	input  lif_pkg::cfg_t cfg,
	input  logic signed [lif_pkg::VAL_W-1:0] cur,
	input  logic signed [lif_pkg::VAL_W-1:0] pot,
	input  logic prev_spk,
	input  logic ext_spk,
	input  logic signed [31:0] wsum,
	output logic signed [lif_pkg::VAL_W-1:0] cur_new,
	output logic signed [lif_pkg::VAL_W-1:0] pot_new,
	output logic spk_new
);
	logic signed [47:0] dec_s1, acc;
	logic signed [lif_pkg::VAL_W-1:0] u_s1, g_s2, u_s2;
	logic signed [47:0] mu_s3, mg_s3, sum;
	logic signed [lif_pkg::VAL_W-1:0] g_s3, p;
	logic signed [31:0] wsum_s1;
	logic ext_s1;

	always_ff @(posedge clk) begin
		if (go) begin
			dec_s1  <= (48'(signed'({1'b0, cfg.current_decay})) * 48'(cur)) >>> 16;
			u_s1    <= prev_spk ? lif_pkg::sat24(48'(pot) - 48'(signed'({1'b0,
				cfg.threshold}))) : pot;
			wsum_s1 <= wsum;
			ext_s1  <= ext_spk;
		end
	end

	always_comb begin
		acc = dec_s1 + 48'(wsum_s1);
		if (ext_s1)
			acc = acc + 48'(cfg.ext_gain);
	end

	always_ff @(posedge clk) begin
		g_s2  <= lif_pkg::sat24(acc);
		u_s2  <= u_s1;
		mu_s3 <= 48'(signed'({1'b0, cfg.membrane_decay})) * 48'(u_s2);
		mg_s3 <= 48'(signed'(18'h10000 - {2'b0, cfg.membrane_decay})) * 48'(g_s2);
		g_s3  <= g_s2;
	end

	assign sum = (mu_s3 + mg_s3) >>> 16;
	assign p   = lif_pkg::sat24(sum);
	assign cur_new = g_s3;
	assign pot_new = p;
	assign spk_new = 48'(p) > 48'(signed'({1'b0, cfg.threshold}));
endmodule

>>> rtl/lif_recurrent_network_step.sv
// Top level of the recurrent leaky integrate-and-fire network step block
// Usage: pulse start with action while busy is low. Load writes one weight
// (post_index, pre_index, weight_value) into the weight memory. Clear zeroes
// all neuron state. Step reads the weight row of each neuron, one weight per
// cycle, sums those whose sender spiked last step, then updates that neuron;
// results leave in neuron order with result_valid high for one cycle each,
// last set on the final neuron. A step keeps busy high until every neuron is
// done: for each neuron it reads and sums the row, then runs the update
// pipeline. Each result shows in the cycle after its neuron is done; the last
// one shows in the first cycle with busy low. Load and clear never raise busy.
// Neuron state sits in a ring of cells that rotates by one each neuron, so
// the update always sees cell 0. Configuration goes through a valid/ready
// write port, ready always high; write only while busy is low.
// Reset clears all neuron state, spikes and registers to their reset values;
// weights are undefined until loaded. The receiver cannot stall: results must
// be taken as they appear.
`timescale 1ns / 1ps
module lif_recurrent_network_step #(
	parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] action,
	input  logic [lif_pkg::IDX_W-1:0] post_index,
	input  logic [lif_pkg::IDX_W-1:0] pre_index,
	input  logic signed [lif_pkg::WEIGHT_W-1:0] weight_value,
	input  logic [63:0] external_spikes,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output logic result_valid,
	output logic [lif_pkg::IDX_W-1:0] neuron,
	output logic signed [lif_pkg::VAL_W-1:0] current,
	output logic signed [lif_pkg::VAL_W-1:0] potential,
	output logic spike,
	output logic last
);
	localparam int NB = $clog2(NEURONS);
	localparam int UPD_LAT = 4;
	localparam int ACC_W = 32;

	lif_pkg::state_t state_q, state_nx;
	lif_pkg::cfg_t cfg_q;
	logic [NB-1:0] nrn_q;
	logic [NB:0] pre_q;
	logic [2:0] upd_q;
	logic [NEURONS-1:0] ext_q, prev_q;
	logic signed [ACC_W-1:0] wsum_q;
	logic signed [lif_pkg::WEIGHT_W-1:0] wmem [2**(2*NB)];
	logic signed [lif_pkg::WEIGHT_W-1:0] wrd_q;
	logic rd_v_q, rd_spk_q;
	logic accept, shift, clear;
	logic signed [lif_pkg::VAL_W-1:0] ccur [NEURONS+1];
	logic signed [lif_pkg::VAL_W-1:0] cpot [NEURONS+1];
	logic cspk [NEURONS+1];
	logic signed [lif_pkg::VAL_W-1:0] cur_new, pot_new;
	logic spk_new;
	logic [NB-1:0] nidx_q;
	logic [NEURONS-1:0] newspk_q;

	assign accept    = start && !busy;
	assign busy      = state_q != lif_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;
	assign clear     = accept && action == lif_pkg::ACT_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.membrane_decay <= 16'd62340;
			cfg_q.current_decay  <= 16'd53656;
			cfg_q.threshold      <= 23'(1 << lif_pkg::FRAC_BITS_DEF);
			cfg_q.ext_gain       <= 16'(1 << lif_pkg::FRAC_BITS_DEF);
		end else if (cfg_valid) begin
			case (cfg_index)
				lif_pkg::REG_MDECAY: cfg_q.membrane_decay <= cfg_data[15:0];
				lif_pkg::REG_CDECAY: cfg_q.current_decay  <= cfg_data[15:0];
				lif_pkg::REG_THR:    cfg_q.threshold      <= cfg_data[22:0];
				lif_pkg::REG_EXTW:   cfg_q.ext_gain       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == lif_pkg::ACT_LOAD && 32'(post_index) < NEURONS
				&& 32'(pre_index) < NEURONS)
			wmem[{post_index[NB-1:0], pre_index[NB-1:0]}] <= weight_value;
		wrd_q <= wmem[{nrn_q, pre_q[NB-1:0]}];
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			lif_pkg::ST_IDLE: if (accept && action == lif_pkg::ACT_STEP) state_nx = lif_pkg::ST_ACC;
			lif_pkg::ST_ACC:  if (!rd_v_q && pre_q == (NB+1)'(NEURONS)) state_nx = lif_pkg::ST_UPD;
			lif_pkg::ST_UPD: begin
				if (upd_q == 3'(UPD_LAT))
					state_nx = (nrn_q == NB'(NEURONS-1)) ? lif_pkg::ST_IDLE : lif_pkg::ST_ACC;
			end
			default: state_nx = lif_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		shift = state_q == lif_pkg::ST_UPD && upd_q == 3'(UPD_LAT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lif_pkg::ST_IDLE;
			nrn_q   <= '0;
			pre_q   <= '0;
			upd_q   <= '0;
			rd_v_q  <= 1'b0;
			prev_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (clear)
				prev_q <= '0;
			case (state_q)
				lif_pkg::ST_IDLE: begin
					nrn_q <= '0;
					pre_q <= '0;
					rd_v_q <= 1'b0;
				end
				lif_pkg::ST_ACC: begin
					rd_v_q <= pre_q < (NB+1)'(NEURONS);
					if (pre_q < (NB+1)'(NEURONS))
						pre_q <= pre_q + 1'b1;
					upd_q <= '0;
				end
				lif_pkg::ST_UPD: begin
					rd_v_q <= 1'b0;
					upd_q <= upd_q + 1'b1;
					if (shift) begin
						pre_q <= '0;
						nrn_q <= nrn_q + 1'b1;
						upd_q <= '0;
					end
					if (shift && nrn_q == NB'(NEURONS-1))
						prev_q <= {spk_new, newspk_q[NEURONS-1:1]};
				end
				default: rd_v_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == lif_pkg::ACT_STEP)
			ext_q <= external_spikes[NEURONS-1:0];
		rd_spk_q <= prev_q[pre_q[NB-1:0]];
		if (state_q == lif_pkg::ST_ACC && pre_q == '0)
			wsum_q <= '0;
		else if (rd_v_q && rd_spk_q)
			wsum_q <= wsum_q + ACC_W'(wrd_q);
		if (shift) begin
			newspk_q <= {spk_new, newspk_q[NEURONS-1:1]};
			nidx_q   <= nrn_q;
		end
	end

	assign ccur[NEURONS] = cur_new;
	assign cpot[NEURONS] = pot_new;
	assign cspk[NEURONS] = spk_new;

	for (genvar k = 0; k < NEURONS; k++) begin : g_cell
		lif_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clear  (clear),
			.cur_in (ccur[k+1]),
			.pot_in (cpot[k+1]),
			.spk_in (cspk[k+1]),
			.cur_out(ccur[k]),
			.pot_out(cpot[k]),
			.spk_out(cspk[k])
		);
	end

	lif_update u_update (
		.clk     (clk),
		.go      (state_q == lif_pkg::ST_UPD && upd_q == 3'd0),
		.cfg     (cfg_q),
		.cur     (ccur[0]),
		.pot     (cpot[0]),
		.prev_spk(cspk[0]),
		.ext_spk (ext_q[nrn_q]),
		.wsum    (wsum_q),
		.cur_new (cur_new),
		.pot_new (pot_new),
		.spk_new (spk_new)
	);

	logic res_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else
			res_v_q <= shift;
	end

	logic signed [lif_pkg::VAL_W-1:0] ocur_q, opot_q;
	logic ospk_q;
	always_ff @(posedge clk) begin
		if (shift) begin
			ocur_q <= cur_new;
			opot_q <= pot_new;
			ospk_q <= spk_new;
		end
	end

	assign result_valid = res_v_q;
	assign neuron    = lif_pkg::IDX_W'(nidx_q);
	assign current   = ocur_q;
	assign potential = opot_q;
	assign spike     = ospk_q;
	assign last      = nidx_q == NB'(NEURONS-1);
endmodule

>>> rtl/lif_checker.sv
// Port checker for the recurrent spiking network step block
`timescale 1ns / 1ps
`include "lif_recurrent_network_step_assert.svh"
module lif_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] action,
	input logic result_valid,
	input logic last
);
	`LIF_ASSERT_NEXT(a_step_busy, arst_n, start && !busy && action == lif_pkg::ACT_STEP, busy, "step did not raise busy")
	`LIF_ASSERT_NEXT(a_load_idle, arst_n, start && !busy && action == lif_pkg::ACT_LOAD, !busy && !result_valid, "load made busy or result")
	`LIF_ASSERT_IMPL(a_res_busy, arst_n, result_valid && !last, busy, "result while idle")
	`LIF_ASSERT_NEXT(a_last_gap, arst_n, result_valid && last, !result_valid, "result after last")
endmodule

bind lif_recurrent_network_step lif_checker u_lif_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
	.result_valid(result_valid), .last(last)
);
